[design/rlpd_pkg.sv]
// rlpd_pkg: shared types and constants of the run-length pair decoder
// command header passed from the front end to the back end, status and phase codes
// no dependencies
`timescale 1ns / 1ps

package rlpd_pkg;

    localparam int BYTE_W         = 8;
    localparam int LANES          = 4;   // decoded bytes carried by one result
    localparam int CNT_W          = 3;   // width of byte_count
    localparam int CAP_W          = 24;  // output_capacity register width
    localparam int WT_W           = 24;  // written_total field width
    localparam int TOTAL_BITS_DEF = 24;  // default width of the running byte total

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CUT      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_FAILED   = 3'd3,
        ST_COMPLETE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_INIT    = 2'd0,
        PH_RUNNING = 2'd1,
        PH_DONE    = 2'd2,
        PH_FAILED  = 2'd3
    } t_phase;

    // one queued command: either a run to expand or a single result
    typedef struct packed {
        logic              is_run;
        t_status           status;
        logic              done;
        logic              last;
        logic [BYTE_W-1:0] count;
        logic [BYTE_W-1:0] value;
    } t_cmd_hdr;

endpackage

[design/rlpd_front.sv]
// rlpd_front: accepts compressed bytes, tracks pair/phase state and capacity,
// and issues run or single-result commands; depends on rlpd_pkg
`timescale 1ns / 1ps

module rlpd_front #(
    parameter int TOTAL_BITS = rlpd_pkg::TOTAL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_mode,
    input  logic [rlpd_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_last,
    input  logic [rlpd_pkg::CAP_W-1:0]   i_capacity,
    input  logic                         i_q_full,
    output logic                         o_ready,
    output logic                         o_push,
    output rlpd_pkg::t_cmd_hdr           o_hdr,
    output logic [TOTAL_BITS-1:0]        o_total
);
    import rlpd_pkg::*;

    localparam int SUM_W = ((TOTAL_BITS > CAP_W) ? TOTAL_BITS : CAP_W) + 1;

    t_phase              r_phase, n_phase;
    logic                r_expect, n_expect;
    logic [BYTE_W-1:0]   r_held, n_held;
    logic [TOTAL_BITS-1:0] r_emitted, n_emitted;
    logic                accept;
    logic                over;
    logic [SUM_W-1:0]    sum;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign sum     = SUM_W'(r_emitted) + SUM_W'(r_held);
    assign over    = sum > SUM_W'(i_capacity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_INIT;
            r_expect  <= 1'b0;
            r_held    <= '0;
            r_emitted <= '0;
        end else begin
            r_phase   <= n_phase;
            r_expect  <= n_expect;
            r_held    <= n_held;
            r_emitted <= n_emitted;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_expect  = r_expect;
        n_held    = r_held;
        n_emitted = r_emitted;
        o_push    = 1'b0;
        o_hdr     = '{is_run: 1'b0, status: ST_OK, done: 1'b0, last: i_last,
                      count: r_held, value: i_byte};
        o_total   = r_emitted;
        if (accept) begin
            if (i_mode) begin
                // restart keeps the capacity register
                n_phase   = PH_INIT;
                n_expect  = 1'b0;
                n_held    = '0;
                n_emitted = '0;
                o_push    = 1'b1;
                o_total   = '0;
            end else begin
                unique case (r_phase)
                    PH_FAILED: begin
                        o_push     = 1'b1;
                        o_hdr.status = ST_FAILED;
                        o_total    = '0;
                    end
                    PH_DONE: begin
                        o_push     = 1'b1;
                        o_hdr.status = ST_COMPLETE;
                        o_hdr.done = 1'b1;
                    end
                    PH_INIT, PH_RUNNING: begin
                        n_phase = PH_RUNNING;
                        if (!r_expect) begin
                            if (i_last) begin
                                // stream ends on a count byte
                                n_phase      = PH_FAILED;
                                o_push       = 1'b1;
                                o_hdr.status = ST_CUT;
                                o_total      = '0;
                            end else begin
                                n_held   = i_byte;
                                n_expect = 1'b1;
                            end
                        end else begin
                            n_expect = 1'b0;
                            if (over) begin
                                n_phase      = PH_FAILED;
                                o_push       = 1'b1;
                                o_hdr.status = ST_OVERFLOW;
                                o_total      = '0;
                            end else begin
                                n_emitted = r_emitted + TOTAL_BITS'(r_held);
                                if (r_held != '0) begin
                                    o_push       = 1'b1;
                                    o_hdr.is_run = 1'b1;
                                end else if (i_last) begin
                                    // empty final run still reports completion
                                    o_push     = 1'b1;
                                    o_hdr.done = 1'b1;
                                end
                                if (i_last) begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

[design/rlpd_queue.sv]
// rlpd_queue: two-entry command queue between front and back end
// generic width; depends on nothing
`timescale 1ns / 1ps

module rlpd_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr, r_rptr;
    logic [1:0]   r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[design/rlpd_back.sv]
// rlpd_back: expands queued commands into results of up to four bytes
// and holds them in the output register; depends on rlpd_pkg
`timescale 1ns / 1ps

module rlpd_back #(
    parameter int TOTAL_BITS = rlpd_pkg::TOTAL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  rlpd_pkg::t_cmd_hdr          i_q_hdr,
    input  logic [TOTAL_BITS-1:0]       i_q_total,
    output logic                        o_pop,
    input  logic                        i_ready,
    output logic                        o_valid,
    output rlpd_pkg::t_status           o_status,
    output logic [rlpd_pkg::CNT_W-1:0]  o_count,
    output logic [rlpd_pkg::BYTE_W-1:0] o_bytes [rlpd_pkg::LANES],
    output logic                        o_run_end,
    output logic                        o_done,
    output logic [rlpd_pkg::WT_W-1:0]   o_written
);
    import rlpd_pkg::*;

    logic                  r_busy;
    t_cmd_hdr              r_hdr;
    logic [BYTE_W-1:0]     r_rem;
    logic [TOTAL_BITS-1:0] r_total;

    logic                  r_valid;
    t_status               r_status;
    logic [CNT_W-1:0]      r_count;
    logic [BYTE_W-1:0]     r_bytes [LANES];
    logic                  r_run_end, r_done;
    logic [WT_W-1:0]       r_written;

    logic                  can_load, fire, fin;
    logic [CNT_W-1:0]      chunk;
    logic [TOTAL_BITS-1:0] tot_n;

    assign can_load = !r_valid || i_ready;
    assign fire     = r_busy && can_load;
    assign chunk    = (r_rem > BYTE_W'(LANES)) ? CNT_W'(LANES) : r_rem[CNT_W-1:0];
    assign fin      = !r_hdr.is_run || (r_rem <= BYTE_W'(LANES));
    assign tot_n    = r_total + TOTAL_BITS'(chunk);
    assign o_pop    = i_q_valid && (!r_busy || (fire && fin));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (fire && fin) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (r_hdr.is_run) begin
                r_status  <= ST_OK;
                r_count   <= chunk;
                for (int i = 0; i < LANES; i++) begin
                    r_bytes[i] <= (CNT_W'(i) < chunk) ? r_hdr.value : '0;
                end
                r_run_end <= fin;
                r_done    <= fin && r_hdr.last;
                r_written <= WT_W'(tot_n);
            end else begin
                r_status  <= r_hdr.status;
                r_count   <= '0;
                for (int i = 0; i < LANES; i++) begin
                    r_bytes[i] <= '0;
                end
                r_run_end <= 1'b1;
                r_done    <= r_hdr.done;
                r_written <= WT_W'(r_total);
            end
        end
        // a new command replaces the finished one, else the run advances
        if (o_pop) begin
            r_hdr   <= i_q_hdr;
            r_rem   <= i_q_hdr.count;
            r_total <= i_q_total;
        end else if (fire && r_hdr.is_run) begin
            r_rem   <= r_rem - BYTE_W'(chunk);
            r_total <= tot_n;
        end
    end

    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_count   = r_count;
    assign o_bytes   = r_bytes;
    assign o_run_end = r_run_end;
    assign o_done    = r_done;
    assign o_written = r_written;

endmodule

[design/run_length_pair_decoder.sv]
// run_length_pair_decoder: top level, stream ports, capacity register and wiring
// depends on rlpd_pkg, rlpd_front, rlpd_queue, rlpd_back
`timescale 1ns / 1ps

// Decodes a stream of (count, value) byte pairs. Each input transaction carries one
// compressed byte (tdata), the end-of-stream mark (tlast) and a restart selector
// (tuser). The front end takes one byte per cycle as long as its two-entry command
// queue has room; a count byte only updates state unless it ends the stream, and a
// value byte queues a nonzero run. The back end turns a run of c bytes into ceil(c/4)
// result transactions, one per cycle while the output side takes them, so a long run
// stalls the input once the queue fills. Errors (cut pair, capacity overflow) and
// single status results give one result transaction each. A result passes the command
// queue and the back end's command and output registers. The capacity register sits at
// byte address 0 of the APB port and should be written only while the decoder is idle.
module run_length_pair_decoder #(
    parameter int TOTAL_BITS = rlpd_pkg::TOTAL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] source_byte
    input  logic        i_s_tlast,    // last_byte
    input  logic        i_s_tuser,    // mode: 1 restart
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] status, [5:3] byte_count, [13:6] out_byte0, [21:14] out_byte1,
    // [29:22] out_byte2, [37:30] out_byte3, [61:38] written_total, [63:62] zero
    output logic [63:0] o_m_tdata,
    output logic        o_m_tlast,    // run_end
    output logic        o_m_tuser,    // stream_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rlpd_pkg::*;

    localparam int QW = $bits(t_cmd_hdr) + TOTAL_BITS;

    logic [CAP_W-1:0]      r_capacity;

    logic                  q_full, q_valid, q_push, q_pop;
    logic [QW-1:0]         q_rdata;
    t_cmd_hdr              push_hdr, pop_hdr;
    logic [TOTAL_BITS-1:0] push_total, pop_total;

    t_status               out_status;
    logic [CNT_W-1:0]      out_count;
    logic [BYTE_W-1:0]     out_bytes [LANES];
    logic [WT_W-1:0]       res_total;

    // capacity register, decoded wherever paddr[2] is low (addresses 0 to 3)
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_capacity) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    rlpd_front #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_mode     (i_s_tuser),
        .i_byte     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_capacity (r_capacity),
        .i_q_full   (q_full),
        .o_ready    (o_s_tready),
        .o_push     (q_push),
        .o_hdr      (push_hdr),
        .o_total    (push_total)
    );

    rlpd_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({push_hdr, push_total}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {pop_hdr, pop_total} = q_rdata;

    rlpd_back #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_hdr   (pop_hdr),
        .i_q_total (pop_total),
        .o_pop     (q_pop),
        .i_ready   (i_m_tready),
        .o_valid   (o_m_tvalid),
        .o_status  (out_status),
        .o_count   (out_count),
        .o_bytes   (out_bytes),
        .o_run_end (o_m_tlast),
        .o_done    (o_m_tuser),
        .o_written (res_total)
    );

    // pack result fields, highest field first
    assign o_m_tdata = {2'b00, res_total, out_bytes[3], out_bytes[2], out_bytes[1],
                        out_bytes[0], out_count, out_status};

endmodule

[sim/tb.sv]
// tb: self-checking bench for run_length_pair_decoder (stream in/out, apb capacity register)
// directed table of pair streams, then random streams, checked against table entries or a local decode model
// depends on rlpd_pkg and run_length_pair_decoder
`timescale 1ns / 1ps

module tb;
    import rlpd_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 8;
    localparam int          QUIET_CYCLES = 6;     // idle wait once every owed result is taken
    localparam int          N_PER_PHASE  = 57;    // random transactions per capacity setting, at least
    localparam int          N_PHASES     = 5;
    localparam int          IDLE_PCT     = 14;
    localparam logic [2:0]  CAP_ADDR     = 3'd0;
    localparam logic        MODE_SOURCE  = 1'b0;
    localparam logic        MODE_RESTART = 1'b1;

    // output tdata as a packed word, fields from the top bit down
    typedef struct packed {
        logic [1:0]  pad;
        logic [23:0] total;
        logic [7:0]  b3;
        logic [7:0]  b2;
        logic [7:0]  b1;
        logic [7:0]  b0;
        logic [2:0]  nbytes;
        t_status     status;
    } rl_word_t;

    typedef struct packed {
        logic     run_end;
        logic     done;
        rl_word_t word;
    } rl_result_t;

    typedef enum {ROW_SRC, ROW_RESTART, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [23:0] arg;       // compressed byte, or capacity for ROW_CAP
        logic        eos;
        bit          typed;     // want holds the single expected result
        rl_result_t  want;
    } dir_row_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = '0;
    logic        i_s_tlast  = 1'b0;
    logic        i_s_tuser  = 1'b0;
    logic        i_m_tready = 1'b1;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;
    logic [31:0] prdata;
    logic        pready;

    run_length_pair_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // decode model state, mirrors the block's state and its capacity register
    logic        dec_expect_value = 1'b0;
    logic [7:0]  dec_held_count   = '0;
    logic [23:0] dec_emitted      = '0;
    t_phase      dec_phase        = PH_INIT;
    logic [23:0] dec_capacity     = 24'hFFFFFF;

    rl_result_t  step_results[$];     // results of the byte just accepted
    rl_result_t  pending_results[$];  // results still owed by the block
    dir_row_t    dir_rows[$];
    int          bad_results = 0;
    int          items_sent  = 0;
    bit          calm        = 1'b0;  // no idling on either side while set

    function automatic rl_result_t make_result(t_status st, int n, logic [7:0] value,
                                               logic run_end, logic done,
                                               logic [23:0] total);
        rl_result_t r;
        r              = '0;
        r.word.status  = st;
        r.word.nbytes  = n[2:0];
        r.word.b0      = (n > 0) ? value : 8'h00;
        r.word.b1      = (n > 1) ? value : 8'h00;
        r.word.b2      = (n > 2) ? value : 8'h00;
        r.word.b3      = (n > 3) ? value : 8'h00;
        r.word.total   = total;
        r.run_end      = run_end;
        r.done         = done;
        return r;
    endfunction

    // single result with no bytes: restarts, errors, completion reports
    function automatic rl_result_t status_only(t_status st, logic done, logic [23:0] total);
        return make_result(st, 0, 8'h00, 1'b1, done, total);
    endfunction

    // expected results of one accepted input transaction
    task automatic decode_step(input logic mode, input logic [7:0] b, input logic eos);
        logic [24:0] need;
        int          left;
        int          n;
        step_results.delete();
        if (mode == MODE_RESTART) begin
            dec_expect_value = 1'b0;
            dec_held_count   = '0;
            dec_emitted      = '0;
            dec_phase        = PH_INIT;
            step_results.push_back(status_only(ST_OK, 1'b0, '0));
            return;
        end
        if (dec_phase == PH_FAILED) begin
            step_results.push_back(status_only(ST_FAILED, 1'b0, '0));
            return;
        end
        if (dec_phase == PH_DONE) begin
            step_results.push_back(status_only(ST_COMPLETE, 1'b1, dec_emitted));
            return;
        end
        dec_phase = PH_RUNNING;
        // count byte: held until its value byte, unless the stream ends here
        if (!dec_expect_value) begin
            if (eos) begin
                dec_phase = PH_FAILED;
                step_results.push_back(status_only(ST_CUT, 1'b0, '0));
            end else begin
                dec_held_count   = b;
                dec_expect_value = 1'b1;
            end
            return;
        end
        dec_expect_value = 1'b0;
        need = {1'b0, dec_emitted} + dec_held_count;
        if (need > {1'b0, dec_capacity}) begin
            dec_phase = PH_FAILED;
            step_results.push_back(status_only(ST_OVERFLOW, 1'b0, '0));
            return;
        end
        // run split into results of up to four lanes
        left = dec_held_count;
        while (left > 0) begin
            n           = (left < LANES) ? left : LANES;
            left        = left - n;
            dec_emitted = dec_emitted + 24'(n);
            step_results.push_back(make_result(ST_OK, n, b, left == 0,
                                               (left == 0) && eos, dec_emitted));
        end
        if (eos) begin
            dec_phase = PH_DONE;
            // zero count at the end still reports completion
            if (step_results.size() == 0)
                step_results.push_back(status_only(ST_OK, 1'b1, dec_emitted));
        end
    endtask

    // one input transaction; called just after posedge i_clk
    task automatic send_item(input logic mode, input logic [7:0] b, input logic eos,
                             input bit typed, input rl_result_t want);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= b;
        i_s_tlast  <= eos;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        decode_step(mode, b, eos);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endtask

    task automatic feed(input logic mode, input logic [7:0] b, input logic eos);
        send_item(mode, b, eos, 1'b0, '0);
    endtask

    // input side quiet, every owed result taken, then a QUIET_CYCLES wait for runs of zero count
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [23:0] value);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CAP_ADDR;
        pwdata  <= {8'h00, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dec_capacity = value;
    endtask

    // mostly short runs, some empty, a few long ones up to the 64-result maximum
    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 8'd0;
        if (r < 75)
            return 8'($urandom_range(1, 12));
        if (r < 93)
            return 8'($urandom_range(13, 64));
        return 8'($urandom_range(65, 255));
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [23:0] arg, input logic eos,
                           input bit typed, input rl_result_t want);
        dir_row_t r;
        r.kind  = kind;
        r.arg   = arg;
        r.eos   = eos;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    // output side: random stalls and the check of each result transaction
    always @(posedge i_clk) begin
        rl_result_t got;
        rl_result_t want;
        i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.run_end = o_m_tlast;
            got.done    = o_m_tuser;
            got.word    = rl_word_t'(o_m_tdata);
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result: tdata %h tlast %b tuser %b",
                             o_m_tdata, o_m_tlast, o_m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("mismatch want: st %0d n %0d bytes %h %h %h %h end %b done %b tot %0d pad %b",
                                 want.word.status, want.word.nbytes, want.word.b0, want.word.b1,
                                 want.word.b2, want.word.b3, want.run_end, want.done,
                                 want.word.total, want.word.pad);
                        $display("           got:  st %0d n %0d bytes %h %h %h %h end %b done %b tot %0d pad %b",
                                 got.word.status, got.word.nbytes, got.word.b0, got.word.b1,
                                 got.word.b2, got.word.b3, got.run_end, got.done,
                                 got.word.total, got.word.pad);
                    end
                end
            end
        end
    end

    // generous ceiling, far above the slowest legal run
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        dir_row_t    row;
        logic [23:0] cap;
        int          start;
        int          choice;
        int          pairs;

        // directed table: default capacity first, then zero and a small exact fit
        add_row(ROW_RESTART, 24'hFF, 1'b1, 1'b1, status_only(ST_OK, 1'b0, '0));
        add_row(ROW_SRC, 24'h00, 1'b0, 1'b0, '0);     // empty run, not last: nothing out
        add_row(ROW_SRC, 24'hAA, 1'b0, 1'b0, '0);
        add_row(ROW_SRC, 24'hFF, 1'b0, 1'b0, '0);     // longest run
        add_row(ROW_SRC, 24'hFF, 1'b0, 1'b0, '0);
        add_row(ROW_SRC, 24'h05, 1'b0, 1'b0, '0);
        add_row(ROW_SRC, 24'h00, 1'b1, 1'b0, '0);     // stream completes at 260 bytes
        add_row(ROW_SRC, 24'h12, 1'b0, 1'b1, status_only(ST_COMPLETE, 1'b1, 24'd260));
        add_row(ROW_RESTART, 24'h00, 1'b0, 1'b1, status_only(ST_OK, 1'b0, '0));
        add_row(ROW_SRC, 24'h07, 1'b1, 1'b1, status_only(ST_CUT, 1'b0, '0));
        add_row(ROW_SRC, 24'h3C, 1'b0, 1'b1, status_only(ST_FAILED, 1'b0, '0));
        add_row(ROW_RESTART, 24'h5A, 1'b0, 1'b1, status_only(ST_OK, 1'b0, '0));
        add_row(ROW_SRC, 24'h00, 1'b0, 1'b0, '0);
        add_row(ROW_SRC, 24'h55, 1'b1, 1'b1, status_only(ST_OK, 1'b1, '0));
        add_row(ROW_CAP, 24'h000000, 1'b0, 1'b0, '0);
        add_row(ROW_RESTART, 24'h00, 1'b1, 1'b1, status_only(ST_OK, 1'b0, '0));
        add_row(ROW_SRC, 24'h01, 1'b0, 1'b0, '0);
        add_row(ROW_SRC, 24'h09, 1'b0, 1'b1, status_only(ST_OVERFLOW, 1'b0, '0));
        add_row(ROW_SRC, 24'h80, 1'b1, 1'b1, status_only(ST_FAILED, 1'b0, '0));
        add_row(ROW_CAP, 24'd6, 1'b0, 1'b0, '0);
        add_row(ROW_RESTART, 24'h00, 1'b0, 1'b1, status_only(ST_OK, 1'b0, '0));
        add_row(ROW_SRC, 24'h06, 1'b0, 1'b0, '0);     // fills capacity exactly
        add_row(ROW_SRC, 24'h81, 1'b0, 1'b0, '0);
        add_row(ROW_SRC, 24'h01, 1'b0, 1'b0, '0);
        add_row(ROW_SRC, 24'h7E, 1'b1, 1'b1, status_only(ST_OVERFLOW, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CAP:     write_capacity(row.arg);
                ROW_RESTART: send_item(MODE_RESTART, row.arg[7:0], row.eos, row.typed, row.want);
                default:     send_item(MODE_SOURCE, row.arg[7:0], row.eos, row.typed, row.want);
            endcase
        end

        // random part: one capacity per phase, mostly well-formed streams
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       cap = 24'hFFFFFF;
                1:       cap = 24'($urandom_range(0, 48));
                2:       cap = 24'($urandom_range(200, 1500));
                3:       cap = 24'($urandom_range(0, 24'hFFFFFF));
                default: cap = 24'h000000;
            endcase
            write_capacity(cap);
            calm  = (ph == 2);
            start = items_sent;
            while (items_sent - start < N_PER_PHASE) begin
                choice = $urandom_range(0, 99);
                if (choice < 70) begin
                    // complete stream, sometimes chained onto the previous one
                    if ($urandom_range(0, 9) != 0)
                        feed(MODE_RESTART, 8'($urandom), 1'($urandom));
                    pairs = $urandom_range(1, 6);
                    for (int k = 0; k < pairs; k++) begin
                        feed(MODE_SOURCE, pick_count(), 1'b0);
                        feed(MODE_SOURCE, 8'($urandom), k == pairs - 1);
                    end
                    if ($urandom_range(0, 3) == 0)
                        feed(MODE_SOURCE, 8'($urandom), 1'($urandom));
                end else if (choice < 85) begin
                    // stream that ends on a count byte
                    feed(MODE_RESTART, 8'($urandom), 1'($urandom));
                    pairs = $urandom_range(0, 3);
                    for (int k = 0; k < pairs; k++) begin
                        feed(MODE_SOURCE, pick_count(), 1'b0);
                        feed(MODE_SOURCE, 8'($urandom), 1'b0);
                    end
                    feed(MODE_SOURCE, 8'($urandom), 1'b1);
                end else begin
                    // noise
                    feed(($urandom_range(0, 7) == 0) ? MODE_RESTART : MODE_SOURCE,
                         8'($urandom), 1'($urandom));
                end
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (bad_results == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/rlpd_pkg.sv
design/rlpd_front.sv
design/rlpd_queue.sv
design/rlpd_back.sv
design/run_length_pair_decoder.sv
sim/tb.sv
